FILE: rtl/bll_pkg.sv
// ----------------------------------------------------------------------------
// bll_pkg
// command and status codes and fixed field widths for the linked list engine
// ----------------------------------------------------------------------------
package bll_pkg;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 2'd0,
        CMD_INS_BACK  = 2'd1,
        CMD_DELETE    = 2'd2,
        CMD_DUMP      = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_EMPTY     = 2'd3
    } status_t;

endpackage

FILE: rtl/bounded_linked_list_engine_unit.sv
// ----------------------------------------------------------------------------
// bounded_linked_list_engine_unit
// singly linked list of signed 32-bit values in a fixed pool of nodes
// ----------------------------------------------------------------------------
// The block keeps a singly linked list of up to CAPACITY signed 32-bit values
// in a node pool, with a free map, a head and a tail pointer. Each input beat
// is one command, given on s_tuser: insert at front, insert at back, delete
// the first node equal to the value, or dump the list. Insert, delete and a
// dump of an empty list give one result beat; a dump of a non-empty list gives
// one beat per node in list order, with m_tlast on the final one. An insert
// into a full pool is dropped and reported as full. The block takes one
// command at a time: s_tready is high only while the sequencer is idle.
// An insert scans the free map one slot per cycle for the lowest free slot
// and, on insert at back into a non-empty list, then writes the old tail's
// link. Delete and dump walk the list through the node memory's single
// registered read port, one node per cycle, visiting at most CAPACITY nodes;
// a dump also waits on m_tready for each beat. The result register lets one
// finished beat wait on the output while the next command is accepted. Node
// memories need no clearing after reset.
module bounded_linked_list_engine_unit
    import bll_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] command
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] data_out, [36:32] count, [39:37] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // last
);

    // slot numbers carry one extra code for null, so they may be wider than
    // the memory address
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SW = $clog2(CAPACITY + 1);
    localparam int CW = SW + COUNT_W;
    localparam logic [SW-1:0] NIL      = SW'(CAPACITY);
    localparam logic [SW-1:0] LAST_STP = SW'(CAPACITY - 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,   // look for the lowest free slot
        ST_LINK = 5'b00100,   // hook new node behind the old tail
        ST_WALK = 5'b01000,   // follow links for delete or dump
        ST_EMIT = 5'b10000    // hand the single status beat to the output
    } state_t;

    // node pool, no reset
    logic [VALUE_W-1:0] node_value_mem [CAPACITY];
    logic [SW-1:0]      node_link_mem  [CAPACITY];

    // control state
    state_t             state_reg, state_next;
    logic [SW-1:0]      head_reg, head_next;
    logic [SW-1:0]      tail_reg, tail_next;
    logic [CAPACITY-1:0] free_reg, free_next;
    logic [SW-1:0]      cnt_reg, cnt_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [SW-1:0]      cur_reg, cur_next;
    logic [SW-1:0]      prev_reg, prev_next;
    logic [SW-1:0]      steps_reg, steps_next;
    logic               mv_reg, mv_next;

    // payload state
    cmd_t               cmd_reg, cmd_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    status_t            sts_reg, sts_next;
    logic [VALUE_W-1:0] rd_value_reg;
    logic [SW-1:0]      rd_link_reg;
    logic [VALUE_W-1:0] mdata_reg, mdata_next;
    status_t            msts_reg, msts_next;
    logic               mlast_reg, mlast_next;
    logic [COUNT_W-1:0] mcnt_reg, mcnt_next;

    // memory ports
    logic [SW-1:0]      rd_slot;
    logic [IW-1:0]      rd_addr;
    logic               val_we;
    logic               link_we;
    logic [IW-1:0]      link_addr;
    logic [SW-1:0]      link_data;

    logic               s_fire;
    logic               out_free;
    logic [CW-1:0]      cnt_ext;
    logic               walk_end;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;
    assign cnt_ext  = CW'(cnt_reg);
    // walk stops at a null link or after CAPACITY nodes
    assign walk_end = (rd_link_reg >= NIL) || (steps_reg == LAST_STP);

    // null and out-of-range slots read slot zero, whose data is then unused
    assign rd_addr = (rd_slot < NIL) ? rd_slot[IW-1:0] : '0;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        free_next  = free_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        steps_next = steps_reg;
        cmd_next   = cmd_reg;
        val_next   = val_reg;
        sts_next   = sts_reg;
        mv_next    = mv_reg && !m_tready;
        mdata_next = mdata_reg;
        msts_next  = msts_reg;
        mlast_next = mlast_reg;
        mcnt_next  = mcnt_reg;
        rd_slot    = cur_reg;
        val_we     = 1'b0;
        link_we    = 1'b0;
        link_addr  = idx_reg;
        link_data  = NIL;

        case (state_reg)
            ST_IDLE:
            begin
                // head is read every idle cycle so a walk finds it ready
                rd_slot = head_reg;
                if (s_fire)
                begin
                    cmd_next   = cmd_t'(s_tuser);
                    val_next   = s_tdata;
                    idx_next   = '0;
                    cur_next   = head_reg;
                    prev_next  = NIL;
                    steps_next = '0;
                    case (cmd_t'(s_tuser))
                        CMD_INS_FRONT, CMD_INS_BACK:
                        begin
                            if (cnt_reg == NIL)
                            begin
                                sts_next   = STS_FULL;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (head_reg >= NIL)
                            begin
                                sts_next   = STS_NOT_FOUND;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            if (head_reg >= NIL)
                            begin
                                sts_next   = STS_EMPTY;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                            end
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (free_reg[idx_reg])
                begin
                    free_next[idx_reg] = 1'b0;
                    cnt_next  = cnt_reg + SW'(1);
                    val_we    = 1'b1;
                    link_we   = 1'b1;
                    link_addr = idx_reg;
                    sts_next  = STS_OK;
                    cur_next  = SW'(idx_reg);
                    if (cmd_reg == CMD_INS_FRONT)
                    begin
                        link_data  = head_reg;
                        head_next  = SW'(idx_reg);
                        if (tail_reg >= NIL)
                            tail_next = SW'(idx_reg);
                        state_next = ST_EMIT;
                    end
                    else if (head_reg >= NIL || tail_reg >= NIL)
                    begin
                        link_data  = NIL;
                        head_next  = SW'(idx_reg);
                        tail_next  = SW'(idx_reg);
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        link_data  = NIL;
                        state_next = ST_LINK;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            ST_LINK:
            begin
                // old tail now points at the new node held in cur
                link_we    = 1'b1;
                link_addr  = tail_reg[IW-1:0];
                link_data  = cur_reg;
                tail_next  = cur_reg;
                state_next = ST_EMIT;
            end

            ST_WALK:
            begin
                if (cmd_reg == CMD_DELETE)
                begin
                    if (rd_value_reg == val_reg)
                    begin
                        if (prev_reg >= NIL)
                        begin
                            head_next = rd_link_reg;
                        end
                        else
                        begin
                            link_we   = 1'b1;
                            link_addr = prev_reg[IW-1:0];
                            link_data = rd_link_reg;
                        end
                        if (tail_reg == cur_reg)
                            tail_next = prev_reg;
                        free_next[cur_reg[IW-1:0]] = 1'b1;
                        if (cnt_reg != '0)
                            cnt_next = cnt_reg - SW'(1);
                        sts_next   = STS_OK;
                        state_next = ST_EMIT;
                    end
                    else if (walk_end)
                    begin
                        sts_next   = STS_NOT_FOUND;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        prev_next  = cur_reg;
                        cur_next   = rd_link_reg;
                        steps_next = steps_reg + SW'(1);
                        rd_slot    = rd_link_reg;
                    end
                end
                else if (out_free)
                begin
                    // dump beat for the current node
                    mv_next    = 1'b1;
                    mdata_next = rd_value_reg;
                    msts_next  = STS_OK;
                    mlast_next = walk_end;
                    mcnt_next  = cnt_ext[COUNT_W-1:0];
                    if (walk_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cur_next   = rd_link_reg;
                        steps_next = steps_reg + SW'(1);
                        rd_slot    = rd_link_reg;
                    end
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    mv_next    = 1'b1;
                    mdata_next = '0;
                    msts_next  = sts_reg;
                    mlast_next = 1'b1;
                    mcnt_next  = cnt_ext[COUNT_W-1:0];
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // node pool: one write per array and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (val_we)
            node_value_mem[idx_reg] <= val_reg;
        if (link_we)
            node_link_mem[link_addr] <= link_data;
        rd_value_reg <= node_value_mem[rd_addr];
        rd_link_reg  <= node_link_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= NIL;
            tail_reg  <= NIL;
            free_reg  <= '1;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            cur_reg   <= NIL;
            prev_reg  <= NIL;
            steps_reg <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            free_reg  <= free_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            cur_reg   <= cur_next;
            prev_reg  <= prev_next;
            steps_reg <= steps_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        val_reg   <= val_next;
        sts_reg   <= sts_next;
        mdata_reg <= mdata_next;
        msts_reg  <= msts_next;
        mlast_reg <= mlast_next;
        mcnt_reg  <= mcnt_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {3'b000, mcnt_reg, mdata_reg};
    assign m_tuser  = msts_reg;
    assign m_tlast  = mlast_reg;

endmodule

FILE: dv/bounded_linked_list_engine_unit_test.sv
// ----------------------------------------------------------------------------
// bounded_linked_list_engine_unit_test
// self-checking bench for the bounded linked list engine
// ----------------------------------------------------------------------------
// A clocked driver sends command beats from a backlog that the stimulus
// process fills. On every accepted command an in-bench list model (node pool,
// free map, head, tail, length) works out the result beats and queues them.
// A clocked monitor pops and compares every accepted result beat field by
// field. The run goes through three back-pressure phases: sender idle 26%
// and receiver 46%, then swapped, then no idling at all.
// ----------------------------------------------------------------------------
module bounded_linked_list_engine_unit_test;
    import bll_pkg::*;

    localparam int CAP         = 16;
    localparam int NIL         = CAP;   // null link
    localparam int STALL_LIMIT = 4000;  // cycles with no beat moving
    localparam int TAIL_WAIT   = 2 * CAP + 8;
    localparam int RAND_ITEMS  = 125;   // per phase

    typedef struct {
        cmd_t        op;
        logic [31:0] value;
    } cmd_beat_t;

    typedef struct {
        status_t     status;
        logic [31:0] data;
        logic        last;
        logic [4:0]  count;
    } list_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;       // [31:0] value
    logic [1:0]  s_tuser = CMD_DUMP; // [1:0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;            // [31:0] data_out, [36:32] count, [39:37] zero
    logic [1:0]  m_tuser;            // [1:0] status
    logic        m_tlast;

    wire cmd_fire = s_tvalid && s_tready;
    wire res_fire = m_tvalid && m_tready;

    // traffic shaping, percent of cycles spent idle
    int src_idle_pct = 0;
    int snk_idle_pct = 0;

    cmd_beat_t   cmd_backlog[$];   // commands not yet presented
    list_beat_t  due_beats[$];     // result beats still owed by the block
    logic [31:0] live_vals[$];     // stimulus-side view of stored values

    // list model state
    logic [31:0] node_val[CAP];
    int          node_nxt[CAP];
    int          head_idx = NIL;
    int          tail_idx = NIL;
    logic [CAP-1:0] free_slots = '1;
    int          list_len = 0;

    // bookkeeping
    int err_cnt    = 0;
    int beats_seen = 0;
    int n_ins      = 0;
    int n_del      = 0;
    int n_dump     = 0;
    int n_full     = 0;
    int n_miss     = 0;
    int n_empty    = 0;
    int max_dump   = 0;
    int quiet_cyc  = 0;

    bounded_linked_list_engine_unit #(
        .CAPACITY (CAP)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // apply one command to the list model and queue the beats it owes
    function automatic void apply_command(input cmd_t op, input logic [31:0] v);
        list_beat_t b;
        int slot;
        int prev;
        int cur;
        int steps;
        bit found;
        b.status = STS_OK;
        b.data   = '0;
        b.last   = 1'b1;
        b.count  = '0;
        case (op)
            CMD_INS_FRONT, CMD_INS_BACK:
            begin
                n_ins++;
                slot = NIL;
                // lowest free slot wins
                for (int i = CAP - 1; i >= 0; i--)
                begin
                    if (free_slots[i])
                        slot = i;
                end
                if (slot == NIL)
                begin
                    b.status = STS_FULL;
                    n_full++;
                end
                else
                begin
                    free_slots[slot] = 1'b0;
                    node_val[slot]   = v;
                    if (op == CMD_INS_FRONT)
                    begin
                        node_nxt[slot] = head_idx;
                        head_idx       = slot;
                        if (tail_idx == NIL)
                            tail_idx = slot;
                    end
                    else
                    begin
                        node_nxt[slot] = NIL;
                        if (head_idx == NIL || tail_idx == NIL)
                            head_idx = slot;
                        else
                            node_nxt[tail_idx] = slot;
                        tail_idx = slot;
                    end
                    list_len++;
                end
                b.count = list_len[4:0];
                due_beats.push_back(b);
            end
            CMD_DELETE:
            begin
                n_del++;
                prev  = NIL;
                cur   = head_idx;
                steps = 0;
                found = 1'b0;
                while (!found && cur != NIL && steps < CAP)
                begin
                    if (node_val[cur] == v)
                    begin
                        found = 1'b1;
                        if (prev == NIL)
                            head_idx = node_nxt[cur];
                        else
                            node_nxt[prev] = node_nxt[cur];
                        // dropping the tail moves it back to the predecessor
                        if (tail_idx == cur)
                            tail_idx = prev;
                        free_slots[cur] = 1'b1;
                        if (list_len > 0)
                            list_len--;
                    end
                    else
                    begin
                        prev = cur;
                        cur  = node_nxt[cur];
                        steps++;
                    end
                end
                if (!found)
                begin
                    b.status = STS_NOT_FOUND;
                    n_miss++;
                end
                b.count = list_len[4:0];
                due_beats.push_back(b);
            end
            default:
            begin
                n_dump++;
                b.count = list_len[4:0];
                if (head_idx == NIL)
                begin
                    b.status = STS_EMPTY;
                    n_empty++;
                    due_beats.push_back(b);
                end
                else
                begin
                    cur   = head_idx;
                    steps = 0;
                    while (cur != NIL && steps < CAP)
                    begin
                        b.data = node_val[cur];
                        b.last = (node_nxt[cur] == NIL) || (steps == CAP - 1);
                        due_beats.push_back(b);
                        cur = node_nxt[cur];
                        steps++;
                    end
                    if (steps > max_dump)
                        max_dump = steps;
                end
            end
        endcase
    endfunction

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        err_cnt++;
        if (err_cnt <= 40)
            $display("mismatch at result beat %0d: %s expected %0h got %0h",
                     beats_seen, what, want, got);
    endtask

    // queue a command and keep the stimulus-side value list roughly in step
    task automatic queue_cmd(input cmd_t op, input logic [31:0] v);
        cmd_beat_t c;
        int hit;
        c.op    = op;
        c.value = v;
        hit     = -1;
        cmd_backlog.push_back(c);
        case (op)
            CMD_INS_FRONT, CMD_INS_BACK:
            begin
                if (live_vals.size() < CAP)
                    live_vals.push_back(v);
            end
            CMD_DELETE:
            begin
                foreach (live_vals[i])
                begin
                    if (hit < 0 && live_vals[i] == v)
                        hit = i;
                end
                if (hit >= 0)
                    live_vals.delete(hit);
            end
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        // small values give duplicates, so first-match delete gets exercised
        if ($urandom_range(0, 3) == 0)
            v = $urandom_range(0, 7);
        else
            v = $urandom();
        return v;
    endfunction

    // random commands; alternating runs lean toward filling and draining the pool
    task automatic queue_random(input int n);
        cmd_t op;
        logic [31:0] v;
        int r;
        bit filling;
        for (int k = 0; k < n; k++)
        begin
            filling = ((k / 30) % 2) == 0;
            r = $urandom_range(0, 99);
            if (r < 12)
                op = CMD_DUMP;
            else if (r < (filling ? 77 : 37))
                op = $urandom_range(0, 1) ? CMD_INS_BACK : CMD_INS_FRONT;
            else
                op = CMD_DELETE;
            v = pick_value();
            // most deletes target a value that is stored, the rest take a random value
            if (op == CMD_DELETE && live_vals.size() != 0 && $urandom_range(0, 3) != 0)
                v = live_vals[$urandom_range(0, live_vals.size() - 1)];
            queue_cmd(op, v);
        end
    endtask

    // settle at the falling edge so the driver's updates are visible
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || s_tvalid || due_beats.size() != 0)
            @(negedge clk);
        repeat (TAIL_WAIT) @(negedge clk);
    endtask

    // driver: keeps a command beat up until it is taken
    always @(posedge clk)
    begin : drive
        cmd_beat_t c;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
                apply_command(cmd_t'(s_tuser), s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    c = cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= c.op;
                    s_tdata  <= c.value;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure and field checks on every result beat
    always @(posedge clk)
    begin : watch
        list_beat_t want;
        if (rst_n)
        begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            if (res_fire)
            begin
                beats_seen++;
                if (due_beats.size() == 0)
                begin
                    report("unexpected beat, data", 32'd0, m_tdata[31:0]);
                end
                else
                begin
                    want = due_beats.pop_front();
                    if (m_tuser != want.status)
                        report("status", 32'(want.status), 32'(m_tuser));
                    if (m_tdata[31:0] != want.data)
                        report("data_out", want.data, m_tdata[31:0]);
                    if (m_tlast != want.last)
                        report("last", 32'(want.last), 32'(m_tlast));
                    if (m_tdata[36:32] != want.count)
                        report("count", 32'(want.count), 32'(m_tdata[36:32]));
                    if (m_tdata[39:37] != 3'd0)
                        report("pad bits", 32'd0, 32'(m_tdata[39:37]));
                end
            end
        end
    end

    // watchdog: ends a run where no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || cmd_fire || res_fire)
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc >= STALL_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles, %0d results owed",
                     quiet_cyc, due_beats.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < CAP; i++)
        begin
            node_val[i] = '0;
            node_nxt[i] = NIL;
        end

        // directed: empty list cases, extreme values, head/tail deletes, miss
        queue_cmd(CMD_DUMP, 32'hFFFF_FFFF);
        queue_cmd(CMD_DELETE, 32'd0);
        queue_cmd(CMD_INS_FRONT, 32'h8000_0000);
        queue_cmd(CMD_INS_BACK, 32'h7FFF_FFFF);
        queue_cmd(CMD_INS_FRONT, 32'hFFFF_FFFF);
        queue_cmd(CMD_INS_BACK, 32'd0);
        queue_cmd(CMD_DUMP, 32'd0);
        queue_cmd(CMD_DELETE, 32'd0);            // tail
        queue_cmd(CMD_DELETE, 32'hFFFF_FFFF);    // head
        queue_cmd(CMD_DELETE, 32'd5);            // not stored
        // fill the pool, with back inserts after the earlier tail delete
        for (int k = 0; k < CAP - 2; k++)
            queue_cmd((k % 2) ? CMD_INS_FRONT : CMD_INS_BACK, $urandom());
        queue_cmd(CMD_INS_FRONT, 32'h1234_5678);  // pool full
        queue_cmd(CMD_INS_BACK, 32'h1234_5678);   // pool full
        queue_cmd(CMD_DUMP, 32'h5555_AAAA);       // full-length dump
        queue_cmd(CMD_DELETE, 32'h7FFF_FFFF);     // middle node

        queue_random(RAND_ITEMS);
        src_idle_pct = 26;
        snk_idle_pct = 46;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        src_idle_pct = 46;
        snk_idle_pct = 26;
        queue_random(RAND_ITEMS);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_random(RAND_ITEMS);
        wait_drained();

        $display("covered %0d commands: %0d inserts, %0d deletes, %0d dumps; %0d result beats",
                 n_ins + n_del + n_dump, n_ins, n_del, n_dump, beats_seen);
        $display("full-pool drops %0d, delete misses %0d, empty dumps %0d, longest dump %0d",
                 n_full, n_miss, n_empty, max_dump);
        if (err_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
